[rtl/tte_pkg.sv]
// Shared widths, types, register codes and tap constants of the echo generator.
package tte_pkg;

  localparam int DATA_W    = 16;
  localparam int DELAY_W   = 13;
  localparam int NUM_TAPS  = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [DELAY_W-1:0]       delay_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_DELAY  = 2'd0,
    REG_SECOND_DELAY = 2'd1,
    REG_THIRD_DELAY  = 2'd2
  } cfg_reg_t;

  // Q15 tap weights: one eighth, one quarter, one half
  localparam sample_t TAP_WEIGHT [NUM_TAPS] = '{16'sh1000, 16'sh2000, 16'sh4000};

  // Tap delays after reset, in samples
  localparam delay_t DELAY_RESET [NUM_TAPS] = '{13'd1024, 13'd2048, 13'd3072};

endpackage

[rtl/tte_in_if.sv]
// Sample input channel: valid/ready handshake carrying one Q15 sample.
interface tte_in_if import tte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/tte_out_if.sv]
// Result channel: valid/ready handshake carrying one saturated Q15 echo sample.
interface tte_out_if import tte_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t echo_out;

  modport source (output valid, output echo_out, input ready);
  modport sink   (input valid, input echo_out, output ready);
endinterface

[rtl/tte_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
module tte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that returns the old word on an address clash
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/three_tap_echo_generator.sv]
// Three-tap feedforward echo generator over a circular sample delay line.
//
// Each input transfer carries one Q15 sample; the block returns the sample plus
// copies from three configurable delays, weighted 1/8, 1/4 and 1/2 with rounding
// and saturating after every addition. One sample is taken per clock cycle when
// neither a stalled output nor settling holds input off. Its result passes the
// delay-line read, registered with the sample, then weighting and summing into
// the output register. The delay line is held in three RAM copies, one per tap,
// all written with the incoming sample, so that the three taps and the write
// share a single cycle. Delays are reduced modulo LINE_DEPTH in a two-stage
// pipeline; input is held off after reset and after each configuration write
// while that settles. Entries not yet written since reset read as silence,
// tracked by the write position and a wrap flag, so no clearing pass is needed.
module three_tap_echo_generator import tte_pkg::*; #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tte_in_if.sink               in_chan,
  tte_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DELAY_W-1:0]   cfg_wdata
);

  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int RECIP  = (1 << DELAY_W) / LINE_DEPTH;
  localparam int PROD_W = 2 * DELAY_W;
  localparam logic [1:0]    SETTLE_CYCLES = 2'd2;
  localparam logic [AW-1:0] WP_LAST       = AW'(LINE_DEPTH - 1);

  // Rounding Q15 multiply: floor((w * x + 2^14) / 2^15)
  function automatic logic signed [DATA_W:0] qmul_round(input sample_t w, input sample_t x);
    logic signed [31:0] prod;
    prod = w * x + 32'sh4000;
    return prod[31:15];
  endfunction

  // Saturating add of a weighted tap onto the running sum
  function automatic sample_t sat_add(input sample_t a, input logic signed [DATA_W:0] b);
    logic signed [DATA_W+1:0] s;
    s = {{2{a[DATA_W-1]}}, a} + {b[DATA_W], b};
    if (s > 18'sd32767) begin
      return 16'sh7fff;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return s[DATA_W-1:0];
    end
  endfunction

  delay_t               dly_r    [NUM_TAPS];
  logic [PROD_W-1:0]    prod_r   [NUM_TAPS];
  logic [AW-1:0]        red_r    [NUM_TAPS];
  logic [AW-1:0]        red_nxt  [NUM_TAPS];
  logic [31:0]          rem      [NUM_TAPS];
  logic [AW-1:0]        rd_addr  [NUM_TAPS];
  sample_t              tap_rd   [NUM_TAPS];
  logic [NUM_TAPS-1:0]  s1_live_r;
  logic [NUM_TAPS-1:0]  live_nxt;
  logic [1:0]           settle_r;
  logic [AW-1:0]        wp_r;
  logic                 wrapped_r;
  logic                 s1_vld_r;
  sample_t              s1_sample_r;
  logic                 out_vld_r;
  sample_t              echo_r;
  sample_t              echo_nxt;
  logic                 in_acc;
  logic                 out_load;

  // Register writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        dly_r[k] <= DELAY_RESET[k];
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FIRST_DELAY:  dly_r[0] <= cfg_wdata;
        REG_SECOND_DELAY: dly_r[1] <= cfg_wdata;
        REG_THIRD_DELAY:  dly_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold off input while the reduced delays settle
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  // Reduce each delay modulo the line depth: reciprocal estimate, then one correction
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      rem[k] = 32'(dly_r[k]) - 32'(prod_r[k][PROD_W-1:DELAY_W]) * 32'(LINE_DEPTH);
      if (rem[k] >= 32'(LINE_DEPTH)) begin
        rem[k] = rem[k] - 32'(LINE_DEPTH);
      end
      red_nxt[k] = AW'(rem[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod_r[k] <= PROD_W'(dly_r[k]) * PROD_W'(RECIP);
      red_r[k]  <= red_nxt[k];
    end
  end

  // Tap addresses behind the write position, and whether each entry was ever written
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (wp_r >= red_r[k]) begin
        rd_addr[k] = wp_r - red_r[k];
      end else begin
        rd_addr[k] = AW'((AW+1)'(wp_r) + (AW+1)'(LINE_DEPTH) - (AW+1)'(red_r[k]));
      end
      live_nxt[k] = wrapped_r || (rd_addr[k] < wp_r);
    end
  end

  // Handshake: input advances when the read stage is free or moving on and the delays have settled
  assign out_load        = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready   = (!s1_vld_r || out_load) && (settle_r == 2'd0);
  assign in_acc          = in_chan.valid && in_chan.ready;

  // One delay-line copy per tap, all written with the accepted sample
  for (genvar gi = 0; gi < NUM_TAPS; gi++) begin : g_line
    tte_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_DEPTH)
    ) u_line (
      .clk   (clk),
      .we    (in_acc),
      .waddr (wp_r),
      .wdata (in_chan.sample_in),
      .re    (in_acc),
      .raddr (rd_addr[gi]),
      .rdata (tap_rd[gi])
    );
  end

  // Advance the write position and note the first wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (in_acc) begin
      if (wp_r == WP_LAST) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  // Read stage: hold the sample alongside the RAM outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (out_load) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_chan.sample_in;
      s1_live_r   <= live_nxt;
    end
  end

  // Weight the taps and sum with saturation at each step
  always_comb begin
    echo_nxt = s1_sample_r;
    for (int k = 0; k < NUM_TAPS; k++) begin
      echo_nxt = sat_add(echo_nxt,
                         qmul_round(TAP_WEIGHT[k], s1_live_r[k] ? tap_rd[k] : '0));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      echo_r <= echo_nxt;
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.echo_out = echo_r;

  // A register write blocks input on the following cycle
  a_cfg_settle : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_chan.ready)
    else $error("input taken while tap delays settle");

  // Each transfer moves the write position on by one
  a_wp_step : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (wp_r != WP_LAST) |=> wp_r == AW'($past(wp_r) + 1'b1))
    else $error("write position did not advance");

  // Once wrapped, the whole line stays live
  a_wrap_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrap flag dropped");

  // A stalled result keeps the read stage and its sample in place
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_chan.ready |=> s1_vld_r && $stable(s1_sample_r))
    else $error("read stage lost an item under stall");

  // An idle output register always takes a waiting item
  a_out_fill : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_vld_r |=> out_vld_r)
    else $error("result not loaded into idle output");

endmodule
